### src/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared constants, register indexes and types of the Sobel edge magnitude
// block: the window layout and the job record passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package sobel_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 2048;
   localparam int MAX_HEIGHT_DEFAULT = 2048;

   localparam int CHAN_W      = 8;
   localparam int RGB_W       = 3 * CHAN_W;
   localparam int COORD_W     = 11;
   localparam int CSR_DATA_W  = 12;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 48;

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   localparam int QUEUE_DEPTH = 16;

   // Configuration register indexes.
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // Result kinds of one job, in the order they are delivered.
   localparam int RES_FIRST = 0;  // column zero of the previous row
   localparam int RES_INT   = 1;  // interior magnitude
   localparam int RES_SIDE  = 2;  // last column of the previous row
   localparam int RES_CUR   = 3;  // top or bottom row pixel as it arrives
   localparam int RES_COUNT = 4;

   // 3x3 gray window, element 3*row+col, row 0 oldest, col 0 leftmost.
   typedef logic [8:0][CHAN_W-1:0] sobel_window_type;

   typedef struct packed {
      logic [RES_COUNT-1:0] emit;
      logic [RGB_W-1:0]     side_rgb;
      logic [RGB_W-1:0]     cur_rgb;
      logic [COORD_W-1:0]   col_cur;
      logic [COORD_W-1:0]   col_int;
      logic [COORD_W-1:0]   row_cur;
      logic [COORD_W-1:0]   row_prev;
      logic [CHAN_W-1:0]    mag;
   } sobel_job_type;

endpackage

`default_nettype wire

### src/sobel_front.sv
// ----------------------------------------------------------------------------
// sobel_front
// Accepts pixels, tracks column and row, classifies the results each pixel
// causes, keeps the two gray line stores and the 3x3 gray window.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_front #(
   parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sobel_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                              csr_valid,
   input  logic                              csr_index,
   input  logic [sobel_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                              job_pop,
   output logic                              win_valid,
   output sobel_pkg::sobel_window_type       win_data,
   output sobel_pkg::sobel_job_type          win_job
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int CXW = (CW > sobel_pkg::COORD_W) ? CW : sobel_pkg::COORD_W;
   localparam int RXW = (RW > sobel_pkg::COORD_W) ? RW : sobel_pkg::COORD_W;
   localparam int WEW = (CW + 1 > sobel_pkg::CSR_DATA_W) ? CW + 1 : sobel_pkg::CSR_DATA_W;
   localparam int HEW = (RW + 1 > sobel_pkg::CSR_DATA_W) ? RW + 1 : sobel_pkg::CSR_DATA_W;
   localparam int QCW = $clog2(sobel_pkg::QUEUE_DEPTH) + 1;
   localparam int W_RST_LAST =
      ((sobel_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : sobel_pkg::RESET_WIDTH) - 1;
   localparam int H_RST_LAST =
      ((sobel_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : sobel_pkg::RESET_HEIGHT) - 1;
   localparam int GRAY_RECIP = 683;
   localparam int GRAY_SHIFT = 11;
   localparam int CH = sobel_pkg::CHAN_W;

   logic [CW-1:0]   w_last_ff, w_last_in, w_clamp;
   logic [RW-1:0]   h_last_ff, h_last_in, h_clamp;
   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic            pending_ff, pending_in;
   logic [sobel_pkg::RGB_W-1:0] first_rgb_ff, first_rgb_in;
   logic [sobel_pkg::RGB_W-1:0] last_rgb_ff, last_rgb_in;
   logic [QCW-1:0]  reserved_ff, reserved_in;

   logic [WEW-1:0]  w_req;
   logic [HEW-1:0]  h_req;
   logic            accept;
   logic            first_row, last_row, first_col, last_col;
   logic [CW-1:0]   col_m1;
   logic [RW-1:0]   row_m1;
   logic [CXW-1:0]  col_x, col_m1_x;
   logic [RXW-1:0]  row_x, row_m1_x;
   logic [9:0]      rgb_sum;
   logic [18:0]     gray_prod;
   logic [CH-1:0]   gray;
   sobel_pkg::sobel_job_type job_in;

   logic            va_ff;
   sobel_pkg::sobel_job_type job_a_ff;
   logic [CH-1:0]   gray_a_ff;
   logic [CW-1:0]   col_a_ff;
   logic [2*CH-1:0] line_rd_ff;  // older in the upper byte, newer in the lower
   logic [2*CH-1:0] line_mem [MAX_WIDTH];

   logic            vb_ff;
   sobel_pkg::sobel_job_type job_b_ff;
   sobel_pkg::sobel_window_type window_ff, window_in;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = reserved_ff < QCW'(sobel_pkg::QUEUE_DEPTH);

   // Size registers hold the clamped size minus one.
   assign w_req = WEW'(csr_data);
   assign h_req = HEW'(csr_data);

   always_comb begin
      priority if (w_req < WEW'(3)) begin
         w_clamp = CW'(2);
      end else if (w_req > WEW'(MAX_WIDTH)) begin
         w_clamp = CW'(MAX_WIDTH - 1);
      end else begin
         w_clamp = CW'(w_req - WEW'(1));
      end
      priority if (h_req < HEW'(3)) begin
         h_clamp = RW'(2);
      end else if (h_req > HEW'(MAX_HEIGHT)) begin
         h_clamp = RW'(MAX_HEIGHT - 1);
      end else begin
         h_clamp = RW'(h_req - HEW'(1));
      end
   end

   assign first_row = row_ff == '0;
   assign last_row  = row_ff == h_last_ff;
   assign first_col = col_ff == '0;
   assign last_col  = col_ff == w_last_ff;
   assign col_m1    = col_ff - CW'(1);
   assign row_m1    = row_ff - RW'(1);
   assign col_x     = CXW'(col_ff);
   assign col_m1_x  = CXW'(col_m1);
   assign row_x     = RXW'(row_ff);
   assign row_m1_x  = RXW'(row_m1);

   // Gray is the channel sum divided by three through a scaled reciprocal,
   // exact for every sum up to 765.
   assign rgb_sum   = 10'(req_tdata[CH-1:0]) + 10'(req_tdata[2*CH-1:CH])
                    + 10'(req_tdata[3*CH-1:2*CH]);
   assign gray_prod = 19'(rgb_sum) * 19'(GRAY_RECIP);
   assign gray      = gray_prod[GRAY_SHIFT +: CH];

   always_comb begin
      job_in                     = '0;
      job_in.emit[sobel_pkg::RES_FIRST] = !first_row && first_col && pending_ff;
      job_in.emit[sobel_pkg::RES_INT]   = (col_ff >= CW'(2)) && (row_ff >= RW'(2));
      job_in.emit[sobel_pkg::RES_SIDE]  = (col_ff >= CW'(2)) && (row_ff >= RW'(2))
                                        && last_col;
      job_in.emit[sobel_pkg::RES_CUR]   = first_row || last_row;
      job_in.side_rgb            = first_col ? first_rgb_ff : last_rgb_ff;
      job_in.cur_rgb             = req_tdata[sobel_pkg::RGB_W-1:0];
      job_in.col_cur             = col_x[sobel_pkg::COORD_W-1:0];
      job_in.col_int             = col_m1_x[sobel_pkg::COORD_W-1:0];
      job_in.row_cur             = row_x[sobel_pkg::COORD_W-1:0];
      job_in.row_prev            = row_m1_x[sobel_pkg::COORD_W-1:0];
   end

   always_comb begin
      w_last_in    = w_last_ff;
      h_last_in    = h_last_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pending_in   = pending_ff;
      first_rgb_in = first_rgb_ff;
      last_rgb_in  = last_rgb_ff;
      reserved_in  = reserved_ff + QCW'(accept) - QCW'(job_pop);
      if (csr_valid) begin
         unique case (csr_index)
            sobel_pkg::CSR_IMAGE_WIDTH:  w_last_in = w_clamp;
            sobel_pkg::CSR_IMAGE_HEIGHT: h_last_in = h_clamp;
            default:                     w_last_in = w_last_ff;
         endcase
         col_in     = '0;
         row_in     = '0;
         pending_in = 1'b0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
         // Rows strictly between top and bottom keep their side pixels for
         // delivery with the next row.
         if (!first_row && first_col) begin
            pending_in = !last_row;
         end
         if (!first_row && !last_row) begin
            if (first_col) begin
               first_rgb_in = req_tdata[sobel_pkg::RGB_W-1:0];
            end
            if (last_col) begin
               last_rgb_in = req_tdata[sobel_pkg::RGB_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff    <= CW'(W_RST_LAST);
         h_last_ff    <= RW'(H_RST_LAST);
         col_ff       <= '0;
         row_ff       <= '0;
         pending_ff   <= 1'b0;
         first_rgb_ff <= '0;
         last_rgb_ff  <= '0;
         reserved_ff  <= '0;
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         window_ff    <= '0;
      end else begin
         w_last_ff    <= w_last_in;
         h_last_ff    <= h_last_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pending_ff   <= pending_in;
         first_rgb_ff <= first_rgb_in;
         last_rgb_ff  <= last_rgb_in;
         reserved_ff  <= reserved_in;
         va_ff        <= accept;
         vb_ff        <= va_ff;
         if (va_ff) begin
            window_ff <= window_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_a_ff  <= job_in;
         gray_a_ff <= gray;
         col_a_ff  <= col_ff;
      end
      job_b_ff <= job_a_ff;
   end

   // Line store: read at accept, written back in the following cycle. Consecutive
   // pixels never share a column, so the read and write never collide.
   always_ff @(posedge clock) begin
      if (accept) begin
         line_rd_ff <= line_mem[col_ff];
      end
      if (va_ff) begin
         line_mem[col_a_ff] <= {line_rd_ff[CH-1:0], gray_a_ff};
      end
   end

   always_comb begin
      window_in = window_ff;
      for (int k = 0; k < 3; k++) begin
         window_in[3*k]     = window_ff[3*k + 1];
         window_in[3*k + 1] = window_ff[3*k + 2];
      end
      window_in[2] = line_rd_ff[2*CH-1:CH];
      window_in[5] = line_rd_ff[CH-1:0];
      window_in[8] = gray_a_ff;
   end

   assign win_valid = vb_ff;
   assign win_data  = window_ff;
   assign win_job   = job_b_ff;

endmodule

`default_nettype wire

### src/sobel_mag.sv
// ----------------------------------------------------------------------------
// sobel_mag
// Pipelined Sobel gradient and magnitude: absolute sums, squares, their sum
// with saturation, then an eight-stage integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_mag (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  sobel_pkg::sobel_window_type  in_window,
   input  sobel_pkg::sobel_job_type     in_job,
   output logic                         out_valid,
   output sobel_pkg::sobel_job_type     out_job
);

   localparam int RAD_W = 16;
   localparam int STEPS = RAD_W / 2;
   localparam int CH    = sobel_pkg::CHAN_W;

   logic signed [10:0] p [9];
   logic signed [10:0] gx, gy;
   logic [9:0]  ax_in, ay_in;

   logic        v1_ff, v2_ff;
   sobel_pkg::sobel_job_type job1_ff, job2_ff;
   logic [9:0]  ax_ff, ay_ff;
   logic [19:0] sqx_ff, sqy_ff;
   logic [20:0] sq_sum;

   logic                      vld_ff  [STEPS+1];
   logic                      sat_ff  [STEPS+1];
   logic [RAD_W-1:0]          rem_ff  [STEPS+1];
   logic [RAD_W:0]            root_ff [STEPS+1];
   sobel_pkg::sobel_job_type  job_ff  [STEPS+1];

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         p[k] = $signed({3'b000, in_window[k]});
      end
   end

   assign gx = (p[2] - p[0]) + ((p[5] - p[3]) <<< 1) + (p[8] - p[6]);
   assign gy = (p[6] + (p[7] <<< 1) + p[8]) - (p[0] + (p[1] <<< 1) + p[2]);
   assign ax_in = (gx < 0) ? 10'(-gx) : 10'(gx);
   assign ay_in = (gy < 0) ? 10'(-gy) : 10'(gy);
   assign sq_sum = 21'(sqx_ff) + 21'(sqy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         vld_ff[0] <= 1'b0;
      end else begin
         v1_ff     <= in_valid;
         v2_ff     <= v1_ff;
         vld_ff[0] <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      job1_ff    <= in_job;
      sqx_ff     <= 20'(ax_ff) * 20'(ax_ff);
      sqy_ff     <= 20'(ay_ff) * 20'(ay_ff);
      job2_ff    <= job1_ff;
      // Any radicand from 2**16 up has a root above 255.
      sat_ff[0]  <= |sq_sum[20:RAD_W];
      rem_ff[0]  <= sq_sum[RAD_W-1:0];
      root_ff[0] <= '0;
      job_ff[0]  <= job2_ff;
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_root
      localparam logic [RAD_W:0] STEP_BIT = (RAD_W + 1)'(1) << (RAD_W - 2 - 2 * k);
      logic [RAD_W:0]   trial;
      logic [RAD_W-1:0] rem_in;
      logic [RAD_W:0]   root_in;

      assign trial = root_ff[k] + STEP_BIT;

      always_comb begin
         if ({1'b0, rem_ff[k]} >= trial) begin
            rem_in  = rem_ff[k] - trial[RAD_W-1:0];
            root_in = (root_ff[k] >> 1) + STEP_BIT;
         end else begin
            rem_in  = rem_ff[k];
            root_in = root_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= rem_in;
         root_ff[k+1] <= root_in;
         sat_ff[k+1]  <= sat_ff[k];
         job_ff[k+1]  <= job_ff[k];
      end
   end

   always_comb begin
      out_job     = job_ff[STEPS];
      out_job.mag = sat_ff[STEPS] ? {CH{1'b1}} : root_ff[STEPS][CH-1:0];
   end

   assign out_valid = vld_ff[STEPS];

endmodule

`default_nettype wire

### src/sobel_queue.sv
// ----------------------------------------------------------------------------
// sobel_queue
// Short job queue between the front pipeline and the result sequencer. The
// front reserves a slot at accept time, so a push always finds room.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sobel_pkg::sobel_job_type  push_job,
   input  logic                      pop,
   output logic                      head_valid,
   output sobel_pkg::sobel_job_type  head_job
);

   localparam int QAW = $clog2(sobel_pkg::QUEUE_DEPTH);

   sobel_pkg::sobel_job_type entry_ff [sobel_pkg::QUEUE_DEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]   count_ff, count_in;

   assign wr_ptr_in = push ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
   assign count_in  = count_ff + (QAW + 1)'(push) - (QAW + 1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_valid = count_ff != '0;
   assign head_job   = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

### src/sobel_back.sv
// ----------------------------------------------------------------------------
// sobel_back
// Result sequencer: walks the results of the job at the queue head, one per
// cycle while the output can take one, into the registered response stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  sobel_pkg::sobel_job_type          head_job,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sobel_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int NR = sobel_pkg::RES_COUNT;
   localparam int PAD_W = sobel_pkg::RSP_DATA_W - sobel_pkg::RGB_W - 2 * sobel_pkg::COORD_W;

   logic [NR-1:0] done_ff, done_in;
   logic [NR-1:0] remaining, sel, rest;
   logic          slot_free, load;
   logic [sobel_pkg::RGB_W-1:0]   res_rgb;
   logic [sobel_pkg::COORD_W-1:0] res_col, res_row;
   logic          res_border;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [sobel_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic          rsp_user_ff, rsp_last_ff;

   assign remaining = head_job.emit & ~done_ff;
   assign rest      = remaining & ~sel;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      sel        = '0;
      res_rgb    = head_job.cur_rgb;
      res_col    = head_job.col_cur;
      res_row    = head_job.row_cur;
      res_border = 1'b1;
      priority if (remaining[sobel_pkg::RES_FIRST]) begin
         sel[sobel_pkg::RES_FIRST] = 1'b1;
         res_rgb = head_job.side_rgb;
         res_col = '0;
         res_row = head_job.row_prev;
      end else if (remaining[sobel_pkg::RES_INT]) begin
         sel[sobel_pkg::RES_INT] = 1'b1;
         res_rgb    = {head_job.mag, head_job.mag, head_job.mag};
         res_col    = head_job.col_int;
         res_row    = head_job.row_prev;
         res_border = 1'b0;
      end else if (remaining[sobel_pkg::RES_SIDE]) begin
         sel[sobel_pkg::RES_SIDE] = 1'b1;
         res_rgb = head_job.side_rgb;
         res_row = head_job.row_prev;
      end else if (remaining[sobel_pkg::RES_CUR]) begin
         sel[sobel_pkg::RES_CUR] = 1'b1;
      end else begin
         sel = '0;
      end
   end

   always_comb begin
      done_in = done_ff;
      pop     = 1'b0;
      load    = 1'b0;
      if (head_valid) begin
         if (remaining == '0) begin
            // A pixel that causes no result leaves without using the output.
            pop     = 1'b1;
            done_in = '0;
         end else if (slot_free) begin
            load = 1'b1;
            if (rest == '0) begin
               pop     = 1'b1;
               done_in = '0;
            end else begin
               done_in = done_ff | sel;
            end
         end
      end
      rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= {{PAD_W{1'b0}}, res_row, res_col, res_rgb};
         rsp_user_ff <= res_border;
         rsp_last_ff <= rest == '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

### src/sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// 3x3 Sobel edge magnitude over an RGB pixel stream in raster order.
//
// Pixels enter on the req_ stream, one request each. Results leave on the
// rsp_ stream with their column and row; the magnitude of an interior pixel
// appears on all three channels, border pixels keep their color and are
// flagged in rsp_tuser. rsp_tlast marks the last result a pixel causes (zero
// to three). Side and interior results trail the input by one row; the top
// and bottom rows come out as they arrive.
// The front accepts one pixel per cycle while fewer than 16 jobs are in its
// pipeline or queue; a job passes the window stages and the magnitude
// pipeline to the queue, and its results are registered in the output
// register. The back emits one result per cycle while the output register
// is free; a pixel with no result leaves the queue without using it.
// The csr_ port sets width (index 0) and height (index 1), clamped to
// 3..MAX_WIDTH/MAX_HEIGHT, and restarts the frame; write only while idle.
// Reset gives a 640x480 frame starting at column 0, row 0; the line stores
// need no clearing. When rsp_tready is low the queue fills and req_tready
// drops; a waiting result is held in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude #(
   parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // red [7:0], green [15:8], blue [23:16]
   input  logic [sobel_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_red [7:0], out_green [15:8], out_blue [23:16], out_col [34:24],
   // out_row [45:35], zero [47:46]
   output logic [sobel_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // is_border [0]
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [sobel_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic                         win_valid;
   sobel_pkg::sobel_window_type  win_data;
   sobel_pkg::sobel_job_type     win_job;
   logic                         mag_valid;
   sobel_pkg::sobel_job_type     mag_job;
   logic                         head_valid;
   sobel_pkg::sobel_job_type     head_job;
   logic                         job_pop;
   logic                         csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   sobel_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .job_pop    (job_pop),
      .win_valid  (win_valid),
      .win_data   (win_data),
      .win_job    (win_job)
   );

   sobel_mag u_mag (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (win_valid),
      .in_window (win_data),
      .in_job    (win_job),
      .out_valid (mag_valid),
      .out_job   (mag_job)
   );

   sobel_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (mag_valid),
      .push_job   (mag_job),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   sobel_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (job_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
